// ----- src/touch_key_qualifier_defines.svh -----
// Assertion macros shared by the checker
`ifndef TOUCH_KEY_QUALIFIER_DEFINES_SVH
`define TOUCH_KEY_QUALIFIER_DEFINES_SVH

// same-cycle implication, gated off during reset
`define TKQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkq: assertion failed");

// next-cycle implication, gated off during reset
`define TKQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkq: assertion failed");

`endif

// ----- src/tkq_pkg.sv -----
`default_nettype none
package tkq_pkg;

  localparam int SAMPLE_BITS = 22;
  localparam int DW          = SAMPLE_BITS + 1;
  localparam int TIME_BITS   = 32;
  localparam int MS_W        = 16;
  localparam int MIN_DELTA_W = 22;
  localparam int CMP_W       = (SAMPLE_BITS > MIN_DELTA_W) ? SAMPLE_BITS : MIN_DELTA_W;
  localparam int CODE_BITS   = 4;
  localparam int NUM_CH      = 5;
  localparam int NUM_BODY    = 3;
  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = 3;

  localparam int ON_FRAMES  = 2;
  localparam int OFF_FRAMES = 4;
  localparam int MASK_MS    = 2000;
  localparam int ON_W       = 2;
  localparam int OFF_W      = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CMP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEAD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ABDOMEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PREV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NEXT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN     = 3'd7;

  localparam logic [MIN_DELTA_W-1:0] MIN_DELTA_RST = 22'd2000;
  localparam logic [MS_W-1:0]        SHORT_MIN_RST = 16'd300;
  localparam logic [MS_W-1:0]        LONG_MIN_RST  = 16'd3000;

  localparam int CH_HEAD    = 0;
  localparam int CH_ABDOMEN = 1;
  localparam int CH_BACK    = 2;
  localparam int CH_PREV    = 3;
  localparam int CH_NEXT    = 4;

  localparam logic [CODE_BITS-1:0] EV_HEAD       = 4'd0;
  localparam logic [CODE_BITS-1:0] EV_ABDOMEN    = 4'd1;
  localparam logic [CODE_BITS-1:0] EV_BACK       = 4'd2;
  localparam logic [CODE_BITS-1:0] EV_HA         = 4'd3;
  localparam logic [CODE_BITS-1:0] EV_HB         = 4'd4;
  localparam logic [CODE_BITS-1:0] EV_AB         = 4'd5;
  localparam logic [CODE_BITS-1:0] EV_PREV_SHORT = 4'd6;
  localparam logic [CODE_BITS-1:0] EV_PREV_LONG  = 4'd7;
  localparam logic [CODE_BITS-1:0] EV_NEXT_SHORT = 4'd8;
  localparam logic [CODE_BITS-1:0] EV_NEXT_LONG  = 4'd9;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_PREV = 2'd1;
  localparam logic [1:0] PH_NEXT = 2'd2;

  // baseline/20 = (baseline>>2)/5 by reciprocal multiply
  localparam int Q_W  = SAMPLE_BITS - 4;
  localparam int Q_XW = SAMPLE_BITS - 2;
  localparam int Q_K  = SAMPLE_BITS + 1;
  localparam int Q_MW = Q_K - 1;
  localparam longint unsigned Q_M = ((64'd1 << Q_K) + 64'd4) / 64'd5;

  // max*7/10 = ((max*7)>>1)/5 by reciprocal multiply
  localparam int T_XW = SAMPLE_BITS + 2;
  localparam int T_K  = SAMPLE_BITS + 4;
  localparam int T_MW = T_K - 1;
  localparam longint unsigned T_M = ((64'd1 << T_K) + 64'd4) / 64'd5;

  typedef struct packed {
    logic                 rel;
    logic                 down;
    logic [TIME_BITS-1:0] held;
  } key_res_t;

  typedef struct packed {
    logic                 vld;
    logic [CODE_BITS-1:0] code;
    logic [TIME_BITS-1:0] held;
  } ev_slot_t;

endpackage
`default_nettype wire

// ----- src/tkq_channels.sv -----
`default_nettype none
interface tkq_in_if;
  logic                             valid;
  logic                             ready;
  logic [tkq_pkg::SAMPLE_BITS-1:0]  sample_head;
  logic [tkq_pkg::SAMPLE_BITS-1:0]  sample_abdomen;
  logic [tkq_pkg::SAMPLE_BITS-1:0]  sample_back;
  logic [tkq_pkg::SAMPLE_BITS-1:0]  sample_prev;
  logic [tkq_pkg::SAMPLE_BITS-1:0]  sample_next;
  logic [tkq_pkg::TIME_BITS-1:0]    now_ms;

  modport source (output valid, sample_head, sample_abdomen, sample_back, sample_prev,
                  sample_next, now_ms, input ready);
  modport sink (input valid, sample_head, sample_abdomen, sample_back, sample_prev,
                sample_next, now_ms, output ready);
endinterface

interface tkq_out_if;
  logic                           valid;
  logic                           ready;
  logic [tkq_pkg::CODE_BITS-1:0]  event_code;
  logic [tkq_pkg::TIME_BITS-1:0]  held_ms;
  logic                           last_event;

  modport source (output valid, event_code, held_ms, last_event, input ready);
  modport sink (input valid, event_code, held_ms, last_event, output ready);
endinterface
`default_nettype wire

// ----- src/tkq_lane.sv -----
`default_nettype none
module tkq_lane (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [tkq_pkg::SAMPLE_BITS-1:0]        sample,
  input  logic [tkq_pkg::SAMPLE_BITS-1:0]        base,
  input  logic [tkq_pkg::MIN_DELTA_W-1:0]        min_delta,
  output logic signed [tkq_pkg::DW-1:0]          delta,
  output logic                                   touched
);

  logic signed [tkq_pkg::DW-1:0]                 d1_r, d1_nxt;
  logic [tkq_pkg::Q_W-1:0]                       q1_r, q1_nxt;
  logic [tkq_pkg::Q_XW+tkq_pkg::Q_MW-1:0]        prod;
  logic signed [tkq_pkg::DW-1:0]                 d2_r;
  logic                                          t2_r, t2_nxt;
  logic [tkq_pkg::SAMPLE_BITS-1:0]               dmag;

  // stage 1: delta and baseline/20
  always_comb begin
    d1_nxt = $signed({1'b0, sample}) - $signed({1'b0, base});
    prod   = base[tkq_pkg::SAMPLE_BITS-1:2] * tkq_pkg::Q_M[tkq_pkg::Q_MW-1:0];
    q1_nxt = prod[tkq_pkg::Q_K +: tkq_pkg::Q_W];
  end

  // stage 2: both thresholds
  always_comb begin
    dmag   = d1_r[tkq_pkg::SAMPLE_BITS-1:0];
    t2_nxt = !d1_r[tkq_pkg::DW-1]
             && (tkq_pkg::CMP_W'(dmag) > tkq_pkg::CMP_W'(min_delta))
             && (dmag > tkq_pkg::SAMPLE_BITS'(q1_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d1_nxt;
      q1_r <= q1_nxt;
      d2_r <= d1_r;
      t2_r <= t2_nxt;
    end
  end

  assign delta   = d2_r;
  assign touched = t2_r;

endmodule
`default_nettype wire

// ----- src/tkq_debounce.sv -----
`default_nettype none
module tkq_debounce (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd,
  input  logic                            clr,
  input  logic                            touched,
  input  logic [tkq_pkg::TIME_BITS-1:0]   now,
  output tkq_pkg::key_res_t               res
);

  logic                            down_r, down_nxt;
  logic [tkq_pkg::ON_W-1:0]        on_r, on_nxt;
  logic [tkq_pkg::OFF_W-1:0]       off_r, off_nxt;
  logic [tkq_pkg::TIME_BITS-1:0]   pt_r, pt_nxt;
  logic [tkq_pkg::ON_W:0]          on_inc;
  logic [tkq_pkg::OFF_W:0]         off_inc;
  logic                            rel;

  always_comb begin
    down_nxt = down_r;
    on_nxt   = on_r;
    off_nxt  = off_r;
    pt_nxt   = pt_r;
    rel      = 1'b0;
    on_inc   = {1'b0, on_r} + (tkq_pkg::ON_W+1)'(1);
    off_inc  = {1'b0, off_r} + (tkq_pkg::OFF_W+1)'(1);
    if (clr) begin
      down_nxt = 1'b0;
      on_nxt   = '0;
      off_nxt  = '0;
      pt_nxt   = '0;
    end else if (touched) begin
      off_nxt = '0;
      if (!down_r) begin
        on_nxt = on_inc[tkq_pkg::ON_W-1:0];
        if (on_inc >= (tkq_pkg::ON_W+1)'(tkq_pkg::ON_FRAMES)) begin
          down_nxt = 1'b1;
          pt_nxt   = now;
        end
      end
    end else begin
      on_nxt = '0;
      if (down_r) begin
        if (off_inc >= (tkq_pkg::OFF_W+1)'(tkq_pkg::OFF_FRAMES)) begin
          rel      = 1'b1;
          down_nxt = 1'b0;
          pt_nxt   = '0;
          off_nxt  = '0;
        end else begin
          off_nxt = off_inc[tkq_pkg::OFF_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r <= 1'b0;
      on_r   <= '0;
      off_r  <= '0;
      pt_r   <= '0;
    end else if (upd) begin
      down_r <= down_nxt;
      on_r   <= on_nxt;
      off_r  <= off_nxt;
      pt_r   <= pt_nxt;
    end
  end

  assign res.rel  = rel;
  assign res.down = down_nxt;
  assign res.held = now - pt_r;

endmodule
`default_nettype wire

// ----- src/tkq_merge.sv -----
`default_nettype none
module tkq_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tkq_pkg::ev_slot_t   slots [tkq_pkg::NUM_SLOTS],
  output logic                load_ok,
  tkq_out_if.source           out_ch
);

  logic [tkq_pkg::NUM_SLOTS-1:0]   vld_r, vld_nxt, rest;
  logic [tkq_pkg::CODE_BITS-1:0]   code_r [tkq_pkg::NUM_SLOTS];
  logic [tkq_pkg::TIME_BITS-1:0]   held_r [tkq_pkg::NUM_SLOTS];
  logic [tkq_pkg::SLOT_W-1:0]      sel;
  logic                            any, last, fire;

  always_comb begin
    sel = '0;
    for (int i = tkq_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (vld_r[i]) begin
        sel = tkq_pkg::SLOT_W'(i);
      end
    end
    rest    = vld_r & (vld_r - tkq_pkg::NUM_SLOTS'(1));
    any     = |vld_r;
    last    = any && (rest == '0);
    fire    = any && out_ch.ready;
    load_ok = !any || (last && out_ch.ready);
    vld_nxt = vld_r;
    if (load) begin
      for (int i = 0; i < tkq_pkg::NUM_SLOTS; i++) begin
        vld_nxt[i] = slots[i].vld;
      end
    end else if (fire) begin
      vld_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < tkq_pkg::NUM_SLOTS; i++) begin
        code_r[i] <= slots[i].code;
        held_r[i] <= slots[i].held;
      end
    end
  end

  assign out_ch.valid      = any;
  assign out_ch.event_code = code_r[sel];
  assign out_ch.held_ms    = held_r[sel];
  assign out_ch.last_event = last;

endmodule
`default_nettype wire

// ----- src/touch_key_qualifier.sv -----
// Touch key qualifier. Each input transaction is one scan frame (five pad samples and
// a millisecond timestamp); each output transaction is one key or combo event, the last
// of a frame flagged by last_event. Five channel lanes take the delta and thresholds in
// two stages, a third stage forms the 70% strongest-key threshold, and the fourth
// updates debounce, combo and page-lock state and loads the frame's events into an
// eight-slot event buffer that drains one event per cycle while the output is ready;
// the first event is shown once the frame has passed both lane stages and the threshold
// and state stages. A frame enters every cycle while the buffer can accept; a frame's
// events hold the next frame back, so the buffer's single output port sets the rate.
// Configuration writes take effect on the next frame and must be made while idle.
`default_nettype none
module touch_key_qualifier (
  input  logic                                  clk,
  input  logic                                  rst_n,
  tkq_in_if.sink                                in_ch,
  tkq_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [tkq_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [tkq_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  logic [tkq_pkg::SAMPLE_BITS-1:0]   base_r [tkq_pkg::NUM_CH];
  logic [tkq_pkg::MIN_DELTA_W-1:0]   min_delta_r;
  logic [tkq_pkg::MS_W-1:0]          short_r;
  logic [tkq_pkg::MS_W-1:0]          long_r;

  logic                              v1_r, v2_r, v3_r;
  logic [tkq_pkg::TIME_BITS-1:0]     now1_r, now2_r, now3_r;
  logic                              en, load_ok, fire4, live, upd;

  logic [tkq_pkg::SAMPLE_BITS-1:0]   sample_in [tkq_pkg::NUM_CH];
  logic signed [tkq_pkg::DW-1:0]     lane_d [tkq_pkg::NUM_CH];
  logic [tkq_pkg::NUM_CH-1:0]        lane_t;

  logic signed [tkq_pkg::DW-1:0]     mx;
  logic [tkq_pkg::SAMPLE_BITS+2:0]   mx7;
  logic [tkq_pkg::T_XW+tkq_pkg::T_MW-1:0] tprod;
  logic [tkq_pkg::SAMPLE_BITS-1:0]   th_nxt, th3_r;
  logic signed [tkq_pkg::DW-1:0]     d3_r [tkq_pkg::NUM_BODY];
  logic [tkq_pkg::NUM_CH-1:0]        touch3_r;

  logic [1:0]                        act;
  logic [tkq_pkg::NUM_BODY-1:0]      hit, inc;
  logic                              cha, chb, cab, pp, np, pb, nb;
  logic [2:0]                        combo_r, combo_nxt;
  logic [1:0]                        ph_r, ph_pre, ph_post, ph_nxt;
  logic [tkq_pkg::NUM_CH-1:0]        key_touch, key_clr;
  tkq_pkg::key_res_t                 res [tkq_pkg::NUM_CH];
  tkq_pkg::ev_slot_t                 slots [tkq_pkg::NUM_SLOTS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tkq_pkg::NUM_CH; i++) begin
        base_r[i] <= '0;
      end
      min_delta_r <= tkq_pkg::MIN_DELTA_RST;
      short_r     <= tkq_pkg::SHORT_MIN_RST;
      long_r      <= tkq_pkg::LONG_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tkq_pkg::CFG_BASE_HEAD:    base_r[tkq_pkg::CH_HEAD] <=
                                     cfg_wdata[tkq_pkg::SAMPLE_BITS-1:0];
        tkq_pkg::CFG_BASE_ABDOMEN: base_r[tkq_pkg::CH_ABDOMEN] <=
                                     cfg_wdata[tkq_pkg::SAMPLE_BITS-1:0];
        tkq_pkg::CFG_BASE_BACK:    base_r[tkq_pkg::CH_BACK] <=
                                     cfg_wdata[tkq_pkg::SAMPLE_BITS-1:0];
        tkq_pkg::CFG_BASE_PREV:    base_r[tkq_pkg::CH_PREV] <=
                                     cfg_wdata[tkq_pkg::SAMPLE_BITS-1:0];
        tkq_pkg::CFG_BASE_NEXT:    base_r[tkq_pkg::CH_NEXT] <=
                                     cfg_wdata[tkq_pkg::SAMPLE_BITS-1:0];
        tkq_pkg::CFG_MIN_DELTA:    min_delta_r <= cfg_wdata[tkq_pkg::MIN_DELTA_W-1:0];
        tkq_pkg::CFG_SHORT_MIN:    short_r <= cfg_wdata[tkq_pkg::MS_W-1:0];
        tkq_pkg::CFG_LONG_MIN:     long_r <= cfg_wdata[tkq_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline control: everything moves unless stage 3 waits on the event buffer
  assign fire4       = v3_r && load_ok;
  assign en          = !v3_r || load_ok;
  assign in_ch.ready = en;
  assign live        = now3_r >= tkq_pkg::TIME_BITS'(tkq_pkg::MASK_MS);
  assign upd         = fire4 && live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sample_in[tkq_pkg::CH_HEAD]    = in_ch.sample_head;
  assign sample_in[tkq_pkg::CH_ABDOMEN] = in_ch.sample_abdomen;
  assign sample_in[tkq_pkg::CH_BACK]    = in_ch.sample_back;
  assign sample_in[tkq_pkg::CH_PREV]    = in_ch.sample_prev;
  assign sample_in[tkq_pkg::CH_NEXT]    = in_ch.sample_next;

  for (genvar g = 0; g < tkq_pkg::NUM_CH; g++) begin : g_lane
    tkq_lane u_lane (
      .clk       (clk),
      .en        (en),
      .sample    (sample_in[g]),
      .base      (base_r[g]),
      .min_delta (min_delta_r),
      .delta     (lane_d[g]),
      .touched   (lane_t[g])
    );
  end

  // stage 3: strongest body delta times 0.7
  always_comb begin
    mx = lane_d[tkq_pkg::CH_HEAD];
    if (lane_d[tkq_pkg::CH_ABDOMEN] > mx) begin
      mx = lane_d[tkq_pkg::CH_ABDOMEN];
    end
    if (lane_d[tkq_pkg::CH_BACK] > mx) begin
      mx = lane_d[tkq_pkg::CH_BACK];
    end
    // only used when two or more body keys are touched, so mx is positive
    mx7    = ({3'b000, mx[tkq_pkg::SAMPLE_BITS-1:0]} << 3)
             - {3'b000, mx[tkq_pkg::SAMPLE_BITS-1:0]};
    tprod  = mx7[tkq_pkg::SAMPLE_BITS+2:1] * tkq_pkg::T_M[tkq_pkg::T_MW-1:0];
    th_nxt = tprod[tkq_pkg::T_K +: tkq_pkg::SAMPLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      now1_r   <= in_ch.now_ms;
      now2_r   <= now1_r;
      now3_r   <= now2_r;
      th3_r    <= th_nxt;
      touch3_r <= lane_t;
      for (int i = 0; i < tkq_pkg::NUM_BODY; i++) begin
        d3_r[i] <= lane_d[i];
      end
    end
  end

  // stage 4: filter, combos, page lock
  always_comb begin
    act = 2'(touch3_r[tkq_pkg::CH_HEAD]) + 2'(touch3_r[tkq_pkg::CH_ABDOMEN])
          + 2'(touch3_r[tkq_pkg::CH_BACK]);
    for (int i = 0; i < tkq_pkg::NUM_BODY; i++) begin
      hit[i] = touch3_r[i] && ((act < 2'd2) || (d3_r[i] >= $signed({1'b0, th3_r})));
    end
    cha    = hit[tkq_pkg::CH_HEAD] && hit[tkq_pkg::CH_ABDOMEN];
    chb    = hit[tkq_pkg::CH_HEAD] && hit[tkq_pkg::CH_BACK];
    cab    = hit[tkq_pkg::CH_ABDOMEN] && hit[tkq_pkg::CH_BACK];
    inc[tkq_pkg::CH_HEAD]    = cha || chb;
    inc[tkq_pkg::CH_ABDOMEN] = cha || cab;
    inc[tkq_pkg::CH_BACK]    = chb || cab;
    pp     = touch3_r[tkq_pkg::CH_PREV];
    np     = touch3_r[tkq_pkg::CH_NEXT];
    ph_pre = ph_r;
    if (ph_r == tkq_pkg::PH_NONE) begin
      if (pp && !np) begin
        ph_pre = tkq_pkg::PH_PREV;
      end else if (np && !pp) begin
        ph_pre = tkq_pkg::PH_NEXT;
      end
    end
    pb = ph_pre == tkq_pkg::PH_NEXT;
    nb = ph_pre == tkq_pkg::PH_PREV;
    key_touch = {np && !nb, pp && !pb, hit};
    key_clr   = {2'b00, inc};
  end

  for (genvar g = 0; g < tkq_pkg::NUM_CH; g++) begin : g_key
    tkq_debounce u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (upd),
      .clr     (key_clr[g]),
      .touched (key_touch[g]),
      .now     (now3_r),
      .res     (res[g])
    );
  end

  always_comb begin
    ph_post = ph_pre;
    if (ph_post == tkq_pkg::PH_PREV && !res[tkq_pkg::CH_PREV].down && !pp) begin
      ph_post = tkq_pkg::PH_NONE;
    end
    if (ph_post == tkq_pkg::PH_NEXT && !res[tkq_pkg::CH_NEXT].down && !np) begin
      ph_post = tkq_pkg::PH_NONE;
    end
    ph_nxt    = upd ? ph_post : ph_r;
    combo_nxt = upd ? {cab, chb, cha} : combo_r;

    slots[0] = '{vld: live && cha && !combo_r[0], code: tkq_pkg::EV_HA, held: '0};
    slots[1] = '{vld: live && chb && !combo_r[1], code: tkq_pkg::EV_HB, held: '0};
    slots[2] = '{vld: live && cab && !combo_r[2], code: tkq_pkg::EV_AB, held: '0};
    for (int i = 0; i < tkq_pkg::NUM_BODY; i++) begin
      slots[3 + i].vld  = live && res[i].rel
                          && (res[i].held >= tkq_pkg::TIME_BITS'(short_r));
      slots[3 + i].code = tkq_pkg::CODE_BITS'(i);
      slots[3 + i].held = res[i].held;
    end
    slots[6].vld  = live && res[tkq_pkg::CH_PREV].rel
                    && (res[tkq_pkg::CH_PREV].held >= tkq_pkg::TIME_BITS'(short_r)
                        || res[tkq_pkg::CH_PREV].held >= tkq_pkg::TIME_BITS'(long_r));
    slots[6].code = (res[tkq_pkg::CH_PREV].held >= tkq_pkg::TIME_BITS'(long_r))
                    ? tkq_pkg::EV_PREV_LONG : tkq_pkg::EV_PREV_SHORT;
    slots[6].held = res[tkq_pkg::CH_PREV].held;
    slots[7].vld  = live && res[tkq_pkg::CH_NEXT].rel
                    && (res[tkq_pkg::CH_NEXT].held >= tkq_pkg::TIME_BITS'(short_r)
                        || res[tkq_pkg::CH_NEXT].held >= tkq_pkg::TIME_BITS'(long_r));
    slots[7].code = (res[tkq_pkg::CH_NEXT].held >= tkq_pkg::TIME_BITS'(long_r))
                    ? tkq_pkg::EV_NEXT_LONG : tkq_pkg::EV_NEXT_SHORT;
    slots[7].held = res[tkq_pkg::CH_NEXT].held;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      combo_r <= '0;
      ph_r    <= tkq_pkg::PH_NONE;
    end else begin
      combo_r <= combo_nxt;
      ph_r    <= ph_nxt;
    end
  end

  tkq_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire4),
    .slots   (slots),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/tkq_checker.sv -----
`default_nettype none
`include "touch_key_qualifier_defines.svh"
module tkq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tkq_pkg::CODE_BITS-1:0]   out_event_code,
  input logic [tkq_pkg::TIME_BITS-1:0]   out_held_ms,
  input logic                            out_last_event
);

  // stalled event is held
  `TKQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_code) && $stable(out_held_ms) && $stable(out_last_event))

  // rest of a frame follows directly
  `TKQ_ASSERT_NXT(a_frame_cont, out_valid && out_ready && !out_last_event, out_valid)

  // combos carry no hold time
  `TKQ_ASSERT_IMP(a_combo_held, out_valid && (out_event_code == tkq_pkg::EV_HA || out_event_code == tkq_pkg::EV_HB || out_event_code == tkq_pkg::EV_AB), out_held_ms == '0)

endmodule

bind touch_key_qualifier tkq_checker u_tkq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_code (out_ch.event_code),
  .out_held_ms    (out_ch.held_ms),
  .out_last_event (out_ch.last_event)
);
`default_nettype wire

// ----- tb/touch_key_qualifier_test.sv -----
`default_nettype none
module touch_key_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tkq_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     MAX_PRINTS = 40;
  localparam longint SMAX = (longint'(1) << SAMPLE_BITS) - 1;
  localparam logic [NUM_BODY-1:0][CODE_BITS-1:0] BODY_EV = {EV_BACK, EV_ABDOMEN, EV_HEAD};

  typedef struct packed {
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] smp;
    logic [TIME_BITS-1:0]               now;
  } frame_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [TIME_BITS-1:0] held;
    logic                 last;
  } key_event_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic   drv_valid = 1'b0;
  frame_t frame_r = '0;
  logic   rdy = 1'b0;

  tkq_in_if  in_ch();
  tkq_out_if out_ch();

  assign in_ch.valid          = drv_valid;
  assign in_ch.sample_head    = frame_r.smp[CH_HEAD];
  assign in_ch.sample_abdomen = frame_r.smp[CH_ABDOMEN];
  assign in_ch.sample_back    = frame_r.smp[CH_BACK];
  assign in_ch.sample_prev    = frame_r.smp[CH_PREV];
  assign in_ch.sample_next    = frame_r.smp[CH_NEXT];
  assign in_ch.now_ms         = frame_r.now;
  assign out_ch.ready         = rdy;

  touch_key_qualifier dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // register mirror
  logic [SAMPLE_BITS-1:0] base_m [NUM_CH] = '{default: '0};
  logic [MIN_DELTA_W-1:0] mind_m = MIN_DELTA_RST;
  logic [MS_W-1:0]        short_m = SHORT_MIN_RST;
  logic [MS_W-1:0]        long_m = LONG_MIN_RST;

  // qualifier state
  logic                 down [NUM_CH] = '{default: 1'b0};
  int                   on_cnt [NUM_CH] = '{default: 0};
  int                   off_cnt [NUM_CH] = '{default: 0};
  logic [TIME_BITS-1:0] t_press [NUM_CH] = '{default: '0};
  logic                 combo_lat [NUM_BODY] = '{default: 1'b0};
  logic [1:0]           holder = PH_NONE;

  frame_t     scan_frames [$];
  key_event_t pending_events [$];
  int n_pushed = 0;
  int n_acc = 0;
  int n_events = 0;
  int n_settings = 0;
  int err_cnt = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit idle_on = 1'b0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void post_event(input logic [CODE_BITS-1:0] code,
                                     input logic [TIME_BITS-1:0] held);
    key_event_t ev;
    ev.code = code;
    ev.held = held;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  // debounce one key; returns 1 with dur set when a release completes
  function automatic logic debounce_key(input int k, input logic hit,
                                        input logic [TIME_BITS-1:0] t,
                                        output logic [TIME_BITS-1:0] dur);
    dur = '0;
    if (hit) begin
      off_cnt[k] = 0;
      if (!down[k]) begin
        on_cnt[k]++;
        if (on_cnt[k] >= ON_FRAMES) begin
          down[k] = 1'b1;
          t_press[k] = t;
        end
      end
      return 1'b0;
    end
    on_cnt[k] = 0;
    if (!down[k]) return 1'b0;
    off_cnt[k]++;
    if (off_cnt[k] < OFF_FRAMES) return 1'b0;
    dur = t - t_press[k];
    down[k] = 1'b0;
    t_press[k] = '0;
    off_cnt[k] = 0;
    return 1'b1;
  endfunction

  function automatic void forecast_events(input frame_t f);
    longint dl [NUM_CH];
    logic   hit [NUM_CH];
    logic   body [NUM_BODY];
    logic   part [NUM_BODY];
    logic   cha, chb, cab, pp, np, pb, nb;
    longint mx, th;
    logic [TIME_BITS-1:0] dur;
    int act, first;
    key_event_t ev;
    first = pending_events.size();
    if (f.now < MASK_MS) return;
    for (int i = 0; i < NUM_CH; i++) begin
      dl[i] = longint'(f.smp[i]) - longint'(base_m[i]);
      hit[i] = dl[i] > longint'(mind_m) && dl[i] > longint'(base_m[i] / 20);
    end
    body[CH_HEAD] = hit[CH_HEAD];
    body[CH_ABDOMEN] = hit[CH_ABDOMEN];
    body[CH_BACK] = hit[CH_BACK];
    act = int'(body[CH_HEAD]) + int'(body[CH_ABDOMEN]) + int'(body[CH_BACK]);
    if (act > 1) begin
      mx = dl[CH_HEAD] > dl[CH_ABDOMEN] ? dl[CH_HEAD] : dl[CH_ABDOMEN];
      mx = mx > dl[CH_BACK] ? mx : dl[CH_BACK];
      th = mx * 7 / 10;
      for (int i = 0; i < NUM_BODY; i++) body[i] = body[i] && dl[i] >= th;
    end
    cha = body[CH_HEAD] && body[CH_ABDOMEN];
    chb = body[CH_HEAD] && body[CH_BACK];
    cab = body[CH_ABDOMEN] && body[CH_BACK];
    if (cha && !combo_lat[0]) begin
      combo_lat[0] = 1'b1;
      post_event(EV_HA, '0);
    end
    if (!cha) combo_lat[0] = 1'b0;
    if (chb && !combo_lat[1]) begin
      combo_lat[1] = 1'b1;
      post_event(EV_HB, '0);
    end
    if (!chb) combo_lat[1] = 1'b0;
    if (cab && !combo_lat[2]) begin
      combo_lat[2] = 1'b1;
      post_event(EV_AB, '0);
    end
    if (!cab) combo_lat[2] = 1'b0;
    part[CH_HEAD] = cha || chb;
    part[CH_ABDOMEN] = cha || cab;
    part[CH_BACK] = chb || cab;
    for (int i = 0; i < NUM_BODY; i++) begin
      if (part[i]) begin
        down[i] = 1'b0;
        on_cnt[i] = 0;
        off_cnt[i] = 0;
        t_press[i] = '0;
      end else if (debounce_key(i, body[i], f.now, dur) && dur >= short_m) begin
        post_event(BODY_EV[i], dur);
      end
    end
    pp = hit[CH_PREV];
    np = hit[CH_NEXT];
    if (holder == PH_NONE) begin
      if (pp && !np) holder = PH_PREV;
      else if (np && !pp) holder = PH_NEXT;
    end
    pb = holder != PH_NONE && holder != PH_PREV;
    nb = holder != PH_NONE && holder != PH_NEXT;
    if (debounce_key(CH_PREV, pp && !pb, f.now, dur)) begin
      if (dur >= long_m) post_event(EV_PREV_LONG, dur);
      else if (dur >= short_m) post_event(EV_PREV_SHORT, dur);
    end
    if (debounce_key(CH_NEXT, np && !nb, f.now, dur)) begin
      if (dur >= long_m) post_event(EV_NEXT_LONG, dur);
      else if (dur >= short_m) post_event(EV_NEXT_SHORT, dur);
    end
    if (holder == PH_PREV && !down[CH_PREV] && !pp) holder = PH_NONE;
    if (holder == PH_NEXT && !down[CH_NEXT] && !np) holder = PH_NONE;
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
  endfunction

  // frame driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        forecast_events(frame_r);
        n_acc <= n_acc + 1;
      end
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          drv_valid <= 1'b0;
        end else if (scan_frames.size() > 0) begin
          frame_r <= scan_frames.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      rdy <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event code %0d held %0d",
                                    out_ch.event_code, out_ch.held_ms));
        end else begin
          want = pending_events.pop_front();
          n_events++;
          if (out_ch.event_code !== want.code)
            report_mismatch($sformatf("event_code %0d, expected %0d",
                                      out_ch.event_code, want.code));
          if (out_ch.held_ms !== want.held)
            report_mismatch($sformatf("held_ms %0d, expected %0d (code %0d)",
                                      out_ch.held_ms, want.held, want.code));
          if (out_ch.last_event !== want.last)
            report_mismatch($sformatf("last_event %b, expected %b (code %0d)",
                                      out_ch.last_event, want.last, want.code));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        rdy <= 1'b0;
      end else begin
        rdy <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d frames of %0d taken, %0d events outstanding",
               n_acc, n_pushed, pending_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BASE_HEAD:    base_m[CH_HEAD] = val;
      CFG_BASE_ABDOMEN: base_m[CH_ABDOMEN] = val;
      CFG_BASE_BACK:    base_m[CH_BACK] = val;
      CFG_BASE_PREV:    base_m[CH_PREV] = val;
      CFG_BASE_NEXT:    base_m[CH_NEXT] = val;
      CFG_MIN_DELTA:    mind_m = val;
      CFG_SHORT_MIN:    short_m = val[MS_W-1:0];
      CFG_LONG_MIN:     long_m = val[MS_W-1:0];
    endcase
  endtask

  task automatic program_regs(input logic [SAMPLE_BITS-1:0] bh, ba, bb, bp, bn,
                              input logic [MIN_DELTA_W-1:0] md,
                              input logic [MS_W-1:0] sm, lm);
    write_reg(CFG_BASE_HEAD, bh);
    write_reg(CFG_BASE_ABDOMEN, ba);
    write_reg(CFG_BASE_BACK, bb);
    write_reg(CFG_BASE_PREV, bp);
    write_reg(CFG_BASE_NEXT, bn);
    write_reg(CFG_MIN_DELTA, md);
    write_reg(CFG_SHORT_MIN, sm);
    write_reg(CFG_LONG_MIN, lm);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pad_level(input int ch, input longint d);
    longint v;
    v = longint'(base_m[ch]) + d;
    if (v < 0) v = 0;
    else if (v > SMAX) v = SMAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic frame_t make_frame(input logic [TIME_BITS-1:0] t,
                                        input longint dh, da, db, dp, dn);
    frame_t f;
    f.now = t;
    f.smp[CH_HEAD] = pad_level(CH_HEAD, dh);
    f.smp[CH_ABDOMEN] = pad_level(CH_ABDOMEN, da);
    f.smp[CH_BACK] = pad_level(CH_BACK, db);
    f.smp[CH_PREV] = pad_level(CH_PREV, dp);
    f.smp[CH_NEXT] = pad_level(CH_NEXT, dn);
    return f;
  endfunction

  // rise over baseline, above or at/below the touch threshold
  function automatic longint pick_delta(input int ch, input logic touch);
    longint thr;
    thr = (base_m[ch] / 20 > mind_m) ? longint'(base_m[ch] / 20) : longint'(mind_m);
    if (touch) return thr + 1 + longint'($urandom_range(0, int'(thr) + 64));
    if ($urandom_range(0, 3) == 0) return -longint'($urandom_range(0, base_m[ch]));
    return longint'($urandom_range(0, int'(thr)));
  endfunction

  task automatic queue_frame(input frame_t f);
    scan_frames.push_back(f);
    n_pushed++;
  endtask

  task automatic wait_taken();
    while (n_acc != n_pushed) @(posedge clk);
  endtask

  task automatic wait_quiet();
    while (n_acc != n_pushed || pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // press/release gestures with bounce, plus raw noise frames
  task automatic run_gestures(input int count, input int unsigned step_lo, step_hi);
    logic [NUM_CH-1:0] keys, cur;
    int hold_n, rel_n, flip, done;
    frame_t f;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int c = 0; c < NUM_CH; c++) f.smp[c] = $urandom;
        case ($urandom_range(0, 2))
          0:       f.now = $urandom;
          1:       f.now = $urandom_range(0, MASK_MS);
          default: f.now = clock_ms;
        endcase
        clock_ms += $urandom_range(step_lo, step_hi);
        queue_frame(f);
        done++;
      end else begin
        keys = $urandom_range(1, 31);
        hold_n = $urandom_range(1, 8);
        rel_n = $urandom_range(1, 6);
        for (int j = 0; j < hold_n + rel_n; j++) begin
          cur = (j < hold_n) ? keys : '0;
          if ($urandom_range(0, 11) == 0) begin
            flip = $urandom_range(0, NUM_CH - 1);
            cur[flip] = ~cur[flip];
          end
          clock_ms += $urandom_range(step_lo, step_hi);
          if ($urandom_range(0, 24) == 0) clock_ms += $urandom_range(0, 80000);
          queue_frame(make_frame(clock_ms, pick_delta(CH_HEAD, cur[CH_HEAD]),
                                 pick_delta(CH_ABDOMEN, cur[CH_ABDOMEN]),
                                 pick_delta(CH_BACK, cur[CH_BACK]),
                                 pick_delta(CH_PREV, cur[CH_PREV]),
                                 pick_delta(CH_NEXT, cur[CH_NEXT])));
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [TIME_BITS-1:0] wrap_t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    program_regs(22'd1000, 22'd1000, 22'd1000, 22'd1000, 22'd1000, 22'd100, 16'd40, 16'd100);
    // power-on mask, full-scale samples
    queue_frame(make_frame(32'd1999, SMAX, SMAX, SMAX, SMAX, SMAX));
    // head short press
    queue_frame(make_frame(32'd2000, 400, 0, 0, 0, 0));
    queue_frame(make_frame(32'd2020, 400, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) queue_frame(make_frame(32'd2040 + 20 * i, 0, 0, 0, 0, 0));
    // head+abdomen combo, latched on the first frame
    queue_frame(make_frame(32'd2200, 400, 400, 0, 0, 0));
    queue_frame(make_frame(32'd2220, 400, 400, 0, 0, 0));
    queue_frame(make_frame(32'd2240, 0, 0, 0, 0, 0));
    // strongest-key filter: back below 70%, then right at 70%
    queue_frame(make_frame(32'd2300, 1000, 0, 500, 0, 0));
    queue_frame(make_frame(32'd2320, 0, 0, 0, 0, 0));
    queue_frame(make_frame(32'd2340, 1000, 0, 700, 0, 0));
    queue_frame(make_frame(32'd2360, 0, 0, 0, 0, 0));
    // both page keys rise together
    queue_frame(make_frame(32'd2400, 0, 0, 0, 400, 400));
    queue_frame(make_frame(32'd2420, 0, 0, 0, 400, 400));
    for (int i = 0; i < 4; i++) queue_frame(make_frame(32'd2440 + 20 * i, 0, 0, 0, 0, 0));
    // prev long hold across the timestamp wrap
    wrap_t = 32'hFFFF_FF00;
    queue_frame(make_frame(wrap_t, 0, 0, 0, 400, 0));
    queue_frame(make_frame(wrap_t + 32'd20, 0, 0, 0, 400, 0));
    for (int i = 0; i < 4; i++) queue_frame(make_frame(32'd2100 + 20 * i, 0, 0, 0, 0, 0));
    wait_quiet();

    program_regs(22'd0, $urandom_range(0, 5000), $urandom_range(0, 5000),
                 $urandom_range(0, 5000), $urandom_range(0, 5000),
                 MIN_DELTA_RST, SHORT_MIN_RST, LONG_MIN_RST);
    clock_ms = 32'd2000 + $urandom_range(0, 100000);
    run_gestures(120, 20, 200);
    wait_quiet();

    program_regs($urandom_range(3000000, 4194303), $urandom_range(3000000, 4194303),
                 $urandom_range(3000000, 4194303), $urandom_range(3000000, 4194303),
                 $urandom_range(3000000, 4194303), 22'd0, 16'd0, 16'hFFFF);
    clock_ms = 32'hFFFF_F000;
    run_gestures(100, 5, 400);
    wait_quiet();

    idle_on = 1'b0;
    program_regs(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                 16'hFFFF, 16'd0);
    run_gestures(30, 10, 100);
    wait_quiet();

    idle_on = 1'b1;
    program_regs($urandom_range(0, 200000), $urandom_range(0, 200000),
                 $urandom_range(0, 200000), $urandom_range(0, 200000),
                 $urandom_range(0, 200000), $urandom_range(0, 20000),
                 $urandom_range(0, 600), $urandom_range(0, 2000));
    clock_ms = 32'd2000 + $urandom;
    run_gestures(70, 10, 150);
    wait_taken();
    idle_on = 1'b0;
    run_gestures(60, 10, 150);
    wait_quiet();

    $display("Ran %0d scan frames through %0d register settings; %0d events checked.",
             n_pushed, n_settings, n_events);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
